// ===== rtl/ksrs_pkg.sv =====
// Shared types, constants and helpers for the keyed stable rank sorter.
`default_nettype none
package ksrs_pkg;

  // Capacity of the key store and width of a sort key.
  localparam int MAX_CANDIDATES = 31;
  localparam int KEY_BITS       = 16;

  // Derived widths: store address, fill count (holds the capacity itself).
  localparam int ADDR_W = $clog2(MAX_CANDIDATES);
  localparam int CNT_W  = $clog2(MAX_CANDIDATES + 1);

  // Fixed field widths of the channels.
  localparam int FIELD_W   = 16;
  localparam int IDX_W     = 6;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_RANK_BY_JOB = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_UNABLE_KEY  = CFG_IDX_W'(1);

  // Reset value of the unable-to-do key.
  localparam logic [FIELD_W-1:0] UNABLE_KEY_RESET = FIELD_W'(65534);

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [IDX_W-1:0]    idx_t;

  // One candidate seen by the minimum scan, and the reference pair of the pass.
  typedef struct packed {
    logic clear;
    logic cand_vld;
    logic first_pass;
    key_t cand_key;
    idx_t cand_idx;
    key_t last_key;
    idx_t last_idx;
  } scan_ctl_t;

  typedef struct packed {
    logic vld;
    key_t key;
    idx_t idx;
  } best_t;

  // Sort key of a record from the mode registers and the record's fields.
  function automatic key_t form_key(input logic               rank_by_job,
                                    input logic [FIELD_W-1:0] unable_key,
                                    input logic               can_do_job,
                                    input logic [FIELD_W-1:0] job_count,
                                    input logic [FIELD_W-1:0] month_total);
    logic [FIELD_W-1:0] k;
    if (rank_by_job) begin
      k = can_do_job ? job_count : unable_key;
    end else begin
      k = month_total;
    end
    return key_t'(k);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ksrs_if.sv =====
// Handshake channel interfaces: candidate records, sorted pairs, register writes.
`default_nettype none
interface ksrs_cand_if;
  logic                          valid;
  logic                          ready;
  logic                          can_do_job;
  logic [ksrs_pkg::FIELD_W-1:0]  job_count;
  logic [ksrs_pkg::FIELD_W-1:0]  month_total;
  logic                          final_record;

  modport source (output valid, can_do_job, job_count, month_total, final_record,
                  input ready);
  modport sink (input valid, can_do_job, job_count, month_total, final_record,
                output ready);
endinterface

interface ksrs_pair_if;
  logic                          valid;
  logic                          ready;
  logic [ksrs_pkg::IDX_W-1:0]    person_index;
  logic [ksrs_pkg::FIELD_W-1:0]  sort_key;
  logic                          last_out;

  modport source (output valid, person_index, sort_key, last_out, input ready);
  modport sink (input valid, person_index, sort_key, last_out, output ready);
endinterface

interface ksrs_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ksrs_pkg::CFG_IDX_W-1:0] reg_index;
  logic [ksrs_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, reg_index, data, input ready);
  modport sink (input valid, reg_index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/ksrs_scan.sv =====
// Minimum scan: finds the smallest (key, index) pair above the last one emitted.
`default_nettype none
module ksrs_scan (
  input  wire                  clk,
  input  wire                  rst,
  input  ksrs_pkg::scan_ctl_t  ctl,
  output ksrs_pkg::best_t      best_next
);

  ksrs_pkg::best_t best;
  logic            above_last;
  logic            better;

  // A candidate is eligible when it sorts after the pair emitted last.
  // Entries arrive in ascending index, so a tie in key never displaces the best.
  always_comb begin
    above_last = ctl.first_pass ||
                 (ctl.cand_key > ctl.last_key) ||
                 ((ctl.cand_key == ctl.last_key) && (ctl.cand_idx > ctl.last_idx));
    better     = !best.vld || (ctl.cand_key < best.key);
    best_next  = ctl.clear ? '0 : best;
    if (!ctl.clear && ctl.cand_vld && above_last && better) begin
      best_next.vld = 1'b1;
      best_next.key = ctl.cand_key;
      best_next.idx = ctl.cand_idx;
    end
  end

  // Running best of the current pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      best <= '0;
    end else begin
      best <= best_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/keyed_stable_rank_sorter.sv =====
// Top level of the keyed stable rank sorter: key store, load path and emit sequencer.
//
// Records are taken one per cycle and their sort keys are written into a
// 31-entry key store; the index of a record is its store address plus one.
// The record flagged final starts the sort, and no record is taken until the
// whole sorted run has been delivered. Each output word comes from one full
// pass over the store through its single read port, which picks the smallest
// (key, index) pair above the one emitted before it, so equal keys keep their
// arrival order. The next pass starts only when the current word is taken.
// Records that arrive when the store holds 31 are dropped. Register writes are
// always accepted.
`default_nettype none
module keyed_stable_rank_sorter (
  input  wire          clk,
  input  wire          rst,
  ksrs_cand_if.sink    cand,
  ksrs_pair_if.source  pair,
  ksrs_cfg_if.sink     cfg
);

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  localparam logic [ksrs_pkg::CNT_W-1:0] CAPACITY =
    ksrs_pkg::CNT_W'(ksrs_pkg::MAX_CANDIDATES);

  logic [1:0]                     state;
  logic [ksrs_pkg::CNT_W-1:0]     count;
  logic [ksrs_pkg::CNT_W-1:0]     n_total;
  logic [ksrs_pkg::CNT_W-1:0]     emit_cnt;
  logic [ksrs_pkg::ADDR_W-1:0]    rd_addr;
  logic [ksrs_pkg::ADDR_W-1:0]    rd_idx;
  logic                           issuing;
  logic                           rd_vld;
  logic                           first_pass;
  ksrs_pkg::key_t                 rd_key;
  ksrs_pkg::key_t                 last_key;
  ksrs_pkg::idx_t                 last_idx;
  ksrs_pkg::key_t                 out_key;
  ksrs_pkg::idx_t                 out_idx;
  logic                           out_last;

  logic                           rank_by_job;
  logic [ksrs_pkg::FIELD_W-1:0]   unable_key;

  ksrs_pkg::key_t                 key_mem [ksrs_pkg::MAX_CANDIDATES];

  logic                           cand_acc;
  logic                           pair_acc;
  logic                           has_room;
  logic                           pass_done;
  ksrs_pkg::scan_ctl_t            scan_ctl;
  ksrs_pkg::best_t                best_next;

  assign cand.ready = (state == ST_LOAD);
  assign cand_acc   = cand.valid && cand.ready;
  assign pair_acc   = pair.valid && pair.ready;
  assign has_room   = (count < CAPACITY);
  assign pass_done  = rd_vld && ((ksrs_pkg::CNT_W'(rd_idx) + 1'b1) == n_total);

  assign pair.valid        = (state == ST_EMIT);
  assign pair.person_index = out_idx;
  assign pair.sort_key     = ksrs_pkg::FIELD_W'(out_key);
  assign pair.last_out     = out_last;

  // Configuration registers.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rank_by_job <= 1'b0;
      unable_key  <= ksrs_pkg::UNABLE_KEY_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.reg_index)
        ksrs_pkg::REG_RANK_BY_JOB: rank_by_job <= cfg.data[0];
        ksrs_pkg::REG_UNABLE_KEY:  unable_key  <= ksrs_pkg::FIELD_W'(cfg.data);
        default: ;
      endcase
    end
  end

  // Key store: written on load, read once per cycle while a pass is issuing.
  always_ff @(posedge clk) begin
    if (cand_acc && has_room) begin
      key_mem[count[ksrs_pkg::ADDR_W-1:0]] <=
        ksrs_pkg::form_key(rank_by_job, unable_key, cand.can_do_job,
                           cand.job_count, cand.month_total);
    end
    if (issuing) begin
      rd_key <= key_mem[rd_addr];
    end
  end

  // Minimum scan over the words returned by the store.
  always_comb begin
    scan_ctl.clear      = cand_acc || pair_acc;
    scan_ctl.cand_vld   = rd_vld;
    scan_ctl.first_pass = first_pass;
    scan_ctl.cand_key   = rd_key;
    scan_ctl.cand_idx   = ksrs_pkg::idx_t'(rd_idx) + 1'b1;
    scan_ctl.last_key   = last_key;
    scan_ctl.last_idx   = last_idx;
  end

  ksrs_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .ctl       (scan_ctl),
    .best_next (best_next)
  );

  // Output word: loaded from the scan result when a pass finishes.
  always_ff @(posedge clk) begin
    if (pass_done) begin
      out_key  <= best_next.key;
      out_idx  <= best_next.idx;
      out_last <= ((emit_cnt + 1'b1) == n_total);
    end
    if (pair_acc) begin
      last_key <= out_key;
      last_idx <= out_idx;
    end
  end

  // Sequencer: load, scan passes and word handoff.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      count      <= '0;
      n_total    <= '0;
      emit_cnt   <= '0;
      rd_addr    <= '0;
      rd_idx     <= '0;
      issuing    <= 1'b0;
      rd_vld     <= 1'b0;
      first_pass <= 1'b0;
    end else begin
      rd_vld <= issuing;
      if (issuing) begin
        rd_idx <= rd_addr;
        if ((ksrs_pkg::CNT_W'(rd_addr) + 1'b1) == n_total) begin
          issuing <= 1'b0;
        end else begin
          rd_addr <= rd_addr + 1'b1;
        end
      end
      case (state)
        ST_LOAD: begin
          if (cand_acc) begin
            if (has_room) begin
              count <= count + 1'b1;
            end
            if (cand.final_record) begin
              n_total    <= has_room ? count + 1'b1 : count;
              emit_cnt   <= '0;
              first_pass <= 1'b1;
              rd_addr    <= '0;
              issuing    <= 1'b1;
              state      <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (pass_done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (pair_acc) begin
            emit_cnt   <= emit_cnt + 1'b1;
            first_pass <= 1'b0;
            if (out_last) begin
              count <= '0;
              state <= ST_LOAD;
            end else begin
              rd_addr <= '0;
              issuing <= 1'b1;
              state   <= ST_SCAN;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // The fill count never passes the store capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAPACITY)
    else $error("fill count above capacity");

  // Store reads only return during a scan pass.
  a_read_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> (state == ST_SCAN))
    else $error("store read outside a scan pass");

  // Every emitted index names a loaded record.
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    pair.valid |-> (pair.person_index != '0) &&
                   (ksrs_pkg::CNT_W'(pair.person_index) <= n_total))
    else $error("emitted index outside the loaded range");

  // Taking the final word of a run empties the store.
  a_run_end: assert property (@(posedge clk) disable iff (rst)
    (pair_acc && pair.last_out) |=> (state == ST_LOAD) && (count == '0))
    else $error("store not emptied after the final word");

endmodule
`default_nettype wire
